>>> design/gmep_pkg.sv
// ----------------------------------------------------------------------------
// gmep_pkg: shared types and constants
// Command codes, result kinds, register indexes, sequencer states and the
// status word that the walk engine hands to the top level.
// ----------------------------------------------------------------------------
package gmep_pkg;

    // Command codes carried in the cmd field
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Result kinds
    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_PATH = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_W  = 1;
    localparam int          CFG_DATA_W = 9;
    localparam logic [0:0]  CFG_WIDTH  = 1'd0;
    localparam logic [0:0]  CFG_HEIGHT = 1'd1;

    // Field widths fixed by the interface
    localparam int IN_ELEV_W = 16;
    localparam int COL_W     = 8;
    localparam int ROW_OUT_W = 8;
    localparam int TOTAL_W   = 24;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

    // Path store depth: one row entry per column
    localparam int PATH_DEPTH = 256;

    // Top level sequencer
    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_READ,
        T_SEND
    } top_state_t;

    // Walk engine sequencer
    typedef enum logic [3:0] {
        W_IDLE,
        W_START,
        W_RD_S,
        W_RD_U,
        W_RD_D,
        W_CAP_D,
        W_DECIDE,
        W_ACCUM,
        W_END,
        W_NEXT,
        W_DONE
    } walk_state_t;

    // Walk engine status toward the top level
    typedef struct packed {
        logic                 done;
        logic [ROW_OUT_W-1:0] best_row;
        logic [TOTAL_W-1:0]   total;
    } walk_stat_t;

endpackage

>>> design/gmep_ram.sv
// ----------------------------------------------------------------------------
// gmep_ram: single-port RAM
// One address per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module gmep_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/gmep_walk.sv
// ----------------------------------------------------------------------------
// gmep_walk: greedy walk engine
// Walks from every row of the first column through the elevation RAM, one
// neighbor read per cycle through a shared abs-difference unit, keeps the
// lowest total, then retraces the best walk into the path RAM.
// ----------------------------------------------------------------------------
module gmep_walk #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int ELEV_BITS  = 16,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WW-1:0]        width,
    input  logic [HW-1:0]        height,
    output logic [AW-1:0]        elev_addr,
    input  logic [ELEV_BITS-1:0] elev_rdata,
    output logic                 path_we,
    output logic [7:0]           path_addr,
    output logic [7:0]           path_wdata,
    output gmep_pkg::walk_stat_t stat
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SUM_W = ((ELEV_BITS > gmep_pkg::TOTAL_W) ? ELEV_BITS
                                                           : gmep_pkg::TOTAL_W) + 1;

    gmep_pkg::walk_state_t state_reg, state_next;

    logic                         trace_reg;
    logic [AW-1:0]                base_reg, best_base_reg, addr_reg;
    logic [RW-1:0]                start_row_reg, best_row_reg, row_reg;
    logic [CW-1:0]                col_reg;
    logic [ELEV_BITS-1:0]         here_reg, s_val_reg, u_val_reg, d_val_reg;
    logic [ELEV_BITS-1:0]         ds_reg, du_reg, dd_reg, delta_reg;
    logic [gmep_pkg::TOTAL_W-1:0] total_reg, low_reg;

    logic [WW-1:0]                w_m1;
    logic [HW-1:0]                h_m1;
    logic                         at_top, at_bottom, last_col, last_start;
    logic [AW-1:0]                straight_addr, up_addr, down_addr;
    logic signed [ELEV_BITS:0]    diff_s;
    logic [ELEV_BITS-1:0]         abs_diff;
    logic                         go_down, go_up;
    logic [SUM_W-1:0]             sum_wide;
    logic [gmep_pkg::TOTAL_W-1:0] total_sat;

    // Position decode
    assign w_m1       = width - WW'(1);
    assign h_m1       = height - HW'(1);
    assign at_top     = (row_reg == '0);
    assign at_bottom  = (HW'(row_reg) == h_m1);
    assign last_col   = (WW'(col_reg) == w_m1);
    assign last_start = (HW'(start_row_reg) == h_m1);

    // Neighbor addresses; an edge row reads straight in place of the missing side
    assign straight_addr = addr_reg + AW'(1);
    assign up_addr       = at_top ? straight_addr : straight_addr - AW'(width);
    assign down_addr     = at_bottom ? straight_addr : straight_addr + AW'(width);

    // Shared abs-difference unit: RAM word against the current sample
    assign diff_s   = $signed({elev_rdata[ELEV_BITS-1], elev_rdata})
                    - $signed({here_reg[ELEV_BITS-1], here_reg});
    assign abs_diff = diff_s[ELEV_BITS] ? ELEV_BITS'(-diff_s) : diff_s[ELEV_BITS-1:0];

    // Step choice: straight wins ties, down wins an up/down tie
    always_comb
    begin
        go_down = 1'b0;
        go_up   = 1'b0;
        priority if (at_top)
        begin
            go_down = (dd_reg < ds_reg);
        end
        else if (at_bottom)
        begin
            go_up = (du_reg < ds_reg);
        end
        else
        begin
            go_down = (dd_reg <= du_reg) && (dd_reg < ds_reg);
            go_up   = !go_down && (du_reg < ds_reg) && (du_reg < dd_reg);
        end
    end

    // Saturating accumulate
    assign sum_wide  = SUM_W'(total_reg) + SUM_W'(delta_reg);
    assign total_sat = (sum_wide > SUM_W'(gmep_pkg::TOTAL_MAX)) ? gmep_pkg::TOTAL_MAX
                                                                : sum_wide[gmep_pkg::TOTAL_W-1:0];

    // Sequencer: next state and RAM port drive
    always_comb
    begin
        state_next = state_reg;
        elev_addr  = addr_reg;
        path_we    = 1'b0;
        path_addr  = 8'(col_reg);
        path_wdata = 8'(row_reg);
        unique case (state_reg)
            gmep_pkg::W_IDLE:
            begin
                if (start)
                begin
                    state_next = gmep_pkg::W_START;
                end
            end
            gmep_pkg::W_START:
            begin
                elev_addr  = base_reg;
                path_we    = trace_reg;
                path_addr  = '0;
                path_wdata = 8'(start_row_reg);
                state_next = (width == WW'(1)) ? gmep_pkg::W_END : gmep_pkg::W_RD_S;
            end
            gmep_pkg::W_RD_S:
            begin
                elev_addr  = straight_addr;
                state_next = gmep_pkg::W_RD_U;
            end
            gmep_pkg::W_RD_U:
            begin
                elev_addr  = up_addr;
                state_next = gmep_pkg::W_RD_D;
            end
            gmep_pkg::W_RD_D:
            begin
                elev_addr  = down_addr;
                state_next = gmep_pkg::W_CAP_D;
            end
            gmep_pkg::W_CAP_D:
            begin
                state_next = gmep_pkg::W_DECIDE;
            end
            gmep_pkg::W_DECIDE:
            begin
                state_next = gmep_pkg::W_ACCUM;
            end
            gmep_pkg::W_ACCUM:
            begin
                path_we    = trace_reg && (int'(col_reg) < gmep_pkg::PATH_DEPTH);
                state_next = last_col ? gmep_pkg::W_END : gmep_pkg::W_RD_S;
            end
            gmep_pkg::W_END:
            begin
                state_next = gmep_pkg::W_NEXT;
            end
            gmep_pkg::W_NEXT:
            begin
                state_next = trace_reg ? gmep_pkg::W_DONE : gmep_pkg::W_START;
            end
            gmep_pkg::W_DONE:
            begin
                state_next = gmep_pkg::W_IDLE;
            end
            default:
            begin
                state_next = gmep_pkg::W_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmep_pkg::W_IDLE;
            trace_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gmep_pkg::W_IDLE && start)
            begin
                trace_reg <= 1'b0;
            end
            else if (state_reg == gmep_pkg::W_NEXT && !trace_reg && last_start)
            begin
                trace_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gmep_pkg::W_IDLE:
            begin
                if (start)
                begin
                    base_reg      <= '0;
                    start_row_reg <= '0;
                end
            end
            gmep_pkg::W_START:
            begin
                addr_reg  <= base_reg;
                row_reg   <= start_row_reg;
                col_reg   <= '0;
                total_reg <= '0;
            end
            gmep_pkg::W_RD_S:
            begin
                // first step: the start sample arrives now
                if (col_reg == '0)
                begin
                    here_reg <= elev_rdata;
                end
            end
            gmep_pkg::W_RD_U:
            begin
                ds_reg    <= abs_diff;
                s_val_reg <= elev_rdata;
            end
            gmep_pkg::W_RD_D:
            begin
                du_reg    <= abs_diff;
                u_val_reg <= elev_rdata;
            end
            gmep_pkg::W_CAP_D:
            begin
                dd_reg    <= abs_diff;
                d_val_reg <= elev_rdata;
            end
            gmep_pkg::W_DECIDE:
            begin
                priority if (go_down)
                begin
                    row_reg   <= row_reg + RW'(1);
                    addr_reg  <= down_addr;
                    here_reg  <= d_val_reg;
                    delta_reg <= dd_reg;
                end
                else if (go_up)
                begin
                    row_reg   <= row_reg - RW'(1);
                    addr_reg  <= up_addr;
                    here_reg  <= u_val_reg;
                    delta_reg <= du_reg;
                end
                else
                begin
                    addr_reg  <= straight_addr;
                    here_reg  <= s_val_reg;
                    delta_reg <= ds_reg;
                end
                col_reg <= col_reg + CW'(1);
            end
            gmep_pkg::W_ACCUM:
            begin
                total_reg <= total_sat;
            end
            gmep_pkg::W_END:
            begin
                // keep the lowest total, earliest start row on a tie
                if (!trace_reg && (start_row_reg == '0 || total_reg < low_reg))
                begin
                    low_reg       <= total_reg;
                    best_row_reg  <= start_row_reg;
                    best_base_reg <= base_reg;
                end
            end
            gmep_pkg::W_NEXT:
            begin
                if (!trace_reg)
                begin
                    if (last_start)
                    begin
                        start_row_reg <= best_row_reg;
                        base_reg      <= best_base_reg;
                    end
                    else
                    begin
                        start_row_reg <= start_row_reg + RW'(1);
                        base_reg      <= base_reg + AW'(width);
                    end
                end
            end
            gmep_pkg::W_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Status toward the top level
    assign stat.done     = (state_reg == gmep_pkg::W_DONE);
    assign stat.best_row = gmep_pkg::ROW_OUT_W'(best_row_reg);
    assign stat.total    = low_reg;

`ifndef SYNTHESIS
    // A step is only decided inside the grid
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gmep_pkg::W_DECIDE) |-> (WW'(col_reg) < w_m1))
        else $error("walk step decided past the last column");

    // Path writes only happen on the retrace
    a_trace_write: assert property (@(posedge clk) disable iff (!rst_n)
        path_we |-> trace_reg)
        else $error("path store written outside the retrace");

    // Decisions never pick two directions
    a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gmep_pkg::W_DECIDE) |-> !(go_down && go_up))
        else $error("walk picked both up and down");
`endif

endmodule

>>> design/greedy_min_elevation_path_top.sv
// ----------------------------------------------------------------------------
// greedy_min_elevation_path_top: greedy minimum elevation change path
// Loads a grid of elevation samples, walks greedily from every first-column
// row, keeps the lowest-change path and answers per-column path queries.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, cmd, elevation, column | into block
//   out     | out_valid, out_stall, result_kind,        | out of block
//           | best_row, best_total, path_row            |
//   cfg     | cfg_we, cfg_index, cfg_data               | into block
//
// Load: one word per cycle, back to back while idle, no result. Read:
// one path RAM read. Run: walks from each of the H rows across the W
// columns, then retraces the best walk; three elevation RAM reads per step.
// in_stall is high for one cycle after reset and after each config write
// while the grid size product settles. A waiting result holds only the
// finishing command; loads go on underneath it.
// ----------------------------------------------------------------------------
module greedy_min_elevation_path_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int ELEV_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          cmd,
    input  logic signed [gmep_pkg::IN_ELEV_W-1:0] elevation,
    input  logic [gmep_pkg::COL_W-1:0]          column,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                result_kind,
    output logic [gmep_pkg::ROW_OUT_W-1:0]      best_row,
    output logic [gmep_pkg::TOTAL_W-1:0]        best_total,
    output logic [gmep_pkg::ROW_OUT_W-1:0]      path_row,
    // configuration
    input  logic                                cfg_we,
    input  logic [gmep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gmep_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int AREA_W = $clog2(DEPTH + 1);
    localparam int W_RST  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int H_RST  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    gmep_pkg::top_state_t state_reg, state_next;

    logic [WW-1:0]                  width_reg;
    logic [HW-1:0]                  height_reg;
    logic [AREA_W-1:0]              area_reg;
    logic                           settle_reg;
    logic [AW-1:0]                  ptr_reg;
    logic [gmep_pkg::ROW_OUT_W-1:0] best_start_reg;
    logic [gmep_pkg::TOTAL_W-1:0]   lowest_total_reg;
    logic [gmep_pkg::COL_W-1:0]     col_q_reg;
    logic                           kind_reg;
    logic [gmep_pkg::ROW_OUT_W-1:0] pend_row_reg;
    logic                           out_valid_reg;
    logic                           out_kind_reg;
    logic [gmep_pkg::ROW_OUT_W-1:0] out_best_reg, out_path_reg;
    logic [gmep_pkg::TOTAL_W-1:0]   out_total_reg;

    logic                           in_acc, out_acc, out_free;
    logic                           walk_start, elev_we;
    logic [WW-1:0]                  w_clamp;
    logic [HW-1:0]                  h_clamp;
    logic [AREA_W-1:0]              ptr_inc;
    logic [AW-1:0]                  walk_addr, elev_addr;
    logic [ELEV_BITS-1:0]           elev_rdata, elev_wdata;
    logic                           path_we;
    logic [7:0]                     walk_path_addr, path_addr, path_wdata, path_rdata;
    gmep_pkg::walk_stat_t           walk_stat;

    // Handshakes
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Config clamp at write time
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            w_clamp = WW'(1);
        end
        else if (int'(cfg_data) > MAX_WIDTH)
        begin
            w_clamp = WW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = WW'(cfg_data);
        end
        priority if (int'(cfg_data) < 2)
        begin
            h_clamp = HW'(2);
        end
        else if (int'(cfg_data) > MAX_HEIGHT)
        begin
            h_clamp = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = HW'(cfg_data);
        end
    end

    // Config registers and settle flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(H_RST);
            settle_reg <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_we;
            if (cfg_we && cfg_index == gmep_pkg::CFG_WIDTH)
            begin
                width_reg <= w_clamp;
            end
            if (cfg_we && cfg_index == gmep_pkg::CFG_HEIGHT)
            begin
                height_reg <= h_clamp;
            end
        end
    end

    // Grid size product for the load wrap
    always_ff @(posedge clk)
    begin
        area_reg <= AREA_W'(width_reg) * AREA_W'(height_reg);
    end

    // Load pointer
    assign ptr_inc = AREA_W'(ptr_reg) + AREA_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (elev_we)
        begin
            ptr_reg <= (ptr_inc >= area_reg) ? '0 : AW'(ptr_inc);
        end
    end

    // Sequencer: next state and strobes
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        walk_start = 1'b0;
        elev_we    = 1'b0;
        unique case (state_reg)
            gmep_pkg::T_IDLE:
            begin
                in_stall = settle_reg;
                if (in_acc)
                begin
                    unique case (cmd)
                        gmep_pkg::CMD_LOAD:
                        begin
                            elev_we = 1'b1;
                        end
                        gmep_pkg::CMD_RUN:
                        begin
                            walk_start = 1'b1;
                            state_next = gmep_pkg::T_RUN;
                        end
                        gmep_pkg::CMD_READ:
                        begin
                            state_next = gmep_pkg::T_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            gmep_pkg::T_RUN:
            begin
                if (walk_stat.done)
                begin
                    state_next = gmep_pkg::T_SEND;
                end
            end
            gmep_pkg::T_READ:
            begin
                state_next = gmep_pkg::T_SEND;
            end
            gmep_pkg::T_SEND:
            begin
                if (out_free)
                begin
                    state_next = gmep_pkg::T_IDLE;
                end
            end
            default:
            begin
                state_next = gmep_pkg::T_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gmep_pkg::T_IDLE;
            best_start_reg   <= '0;
            lowest_total_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gmep_pkg::T_RUN && walk_stat.done)
            begin
                best_start_reg   <= walk_stat.best_row;
                lowest_total_reg <= walk_stat.total;
            end
            if (state_reg == gmep_pkg::T_SEND && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pending result and output word
    always_ff @(posedge clk)
    begin
        if (state_reg == gmep_pkg::T_IDLE && in_acc)
        begin
            col_q_reg <= column;
        end
        if (state_reg == gmep_pkg::T_RUN && walk_stat.done)
        begin
            kind_reg     <= gmep_pkg::KIND_RUN;
            pend_row_reg <= '0;
        end
        if (state_reg == gmep_pkg::T_READ)
        begin
            kind_reg     <= gmep_pkg::KIND_PATH;
            pend_row_reg <= (int'(col_q_reg) < int'(width_reg)) ? path_rdata : '0;
        end
        if (state_reg == gmep_pkg::T_SEND && out_free)
        begin
            out_kind_reg  <= kind_reg;
            out_best_reg  <= best_start_reg;
            out_total_reg <= lowest_total_reg;
            out_path_reg  <= pend_row_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign best_row    = out_best_reg;
    assign best_total  = out_total_reg;
    assign path_row    = out_path_reg;

    // Elevation RAM: load writes while idle, walk engine reads during a run
    assign elev_wdata = ELEV_BITS'(elevation);
    assign elev_addr  = (state_reg == gmep_pkg::T_RUN) ? walk_addr : ptr_reg;

    gmep_ram #(
        .WIDTH (ELEV_BITS),
        .DEPTH (DEPTH)
    ) u_elev_ram (
        .clk   (clk),
        .we    (elev_we),
        .addr  (elev_addr),
        .wdata (elev_wdata),
        .rdata (elev_rdata)
    );

    // Path RAM: retrace writes during a run, query reads while idle
    assign path_addr = (state_reg == gmep_pkg::T_RUN) ? walk_path_addr : column;

    gmep_ram #(
        .WIDTH (8),
        .DEPTH (gmep_pkg::PATH_DEPTH)
    ) u_path_ram (
        .clk   (clk),
        .we    (path_we),
        .addr  (path_addr),
        .wdata (path_wdata),
        .rdata (path_rdata)
    );

    // Walk engine
    gmep_walk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ELEV_BITS  (ELEV_BITS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (walk_start),
        .width      (width_reg),
        .height     (height_reg),
        .elev_addr  (walk_addr),
        .elev_rdata (elev_rdata),
        .path_we    (path_we),
        .path_addr  (walk_path_addr),
        .path_wdata (path_wdata),
        .stat       (walk_stat)
    );

`ifndef SYNTHESIS
    // Walk completion is only seen while a run is pending
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        walk_stat.done |-> (state_reg == gmep_pkg::T_RUN))
        else $error("walk done outside a run");

    // A waiting output word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gmep_pkg::T_SEND && out_valid_reg && out_stall)
            |=> (state_reg == gmep_pkg::T_SEND))
        else $error("result sent while output word still held");

    // Path RAM written only during a run
    a_path_we_run: assert property (@(posedge clk) disable iff (!rst_n)
        path_we |-> (state_reg == gmep_pkg::T_RUN))
        else $error("path store written outside a run");

    // Elevation RAM written only while no run holds the port
    a_elev_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        elev_we |-> (state_reg == gmep_pkg::T_IDLE && !settle_reg))
        else $error("sample loaded while busy");
`endif

endmodule

>>> verif/greedy_min_elevation_path_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_min_elevation_path_top_test: self-checking bench for the path finder
// Loads elevation grids of many sizes, runs the greedy walk and queries the
// traced path column by column. A scoreboard object mirrors the grid store,
// the load pointer and the path store, predicts every run summary and path
// answer, and compares each result word field by field as it leaves the block.
// ----------------------------------------------------------------------------
module greedy_min_elevation_path_top_test;

    localparam int GRID_DEPTH   = 65536;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_WORDS = 400;
    localparam int SETTLE       = 20;

    typedef struct {
        logic                           kind;
        logic [gmep_pkg::ROW_OUT_W-1:0] start_row;
        logic [gmep_pkg::TOTAL_W-1:0]   total;
        logic [gmep_pkg::ROW_OUT_W-1:0] row_at_col;
    } path_answer_t;

    // Mirror of the grid, pointer and path store; predicts and checks results
    class path_scoreboard;
        logic signed [gmep_pkg::IN_ELEV_W-1:0] elev_mem [GRID_DEPTH];
        bit                                    sample_loaded [GRID_DEPTH];
        logic [gmep_pkg::ROW_OUT_W-1:0]        trace_mem [gmep_pkg::PATH_DEPTH];
        int unsigned                           load_ptr;
        logic [gmep_pkg::CFG_DATA_W-1:0]       width_reg;
        logic [gmep_pkg::CFG_DATA_W-1:0]       height_reg;
        logic [gmep_pkg::ROW_OUT_W-1:0]        best_start;
        logic [gmep_pkg::TOTAL_W-1:0]          lowest_total;
        path_answer_t                          answers [$];
        int                                    errors;

        function new();
            load_ptr     = 0;
            width_reg    = 9'd256;
            height_reg   = 9'd256;
            best_start   = '0;
            lowest_total = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [gmep_pkg::CFG_IDX_W-1:0] idx,
                              logic [gmep_pkg::CFG_DATA_W-1:0] val);
            if (idx == gmep_pkg::CFG_WIDTH)
                width_reg = val;
            else
                height_reg = val;
        endfunction

        // Sizes in use after clamping
        function int unsigned cols();
            if (width_reg < 1) return 1;
            if (width_reg > 256) return 256;
            return 32'(width_reg);
        endfunction

        function int unsigned rows();
            if (height_reg < 2) return 2;
            if (height_reg > 256) return 256;
            return 32'(height_reg);
        endfunction

        function bit grid_ready();
            for (int a = 0; a < cols() * rows(); a++)
                if (!sample_loaded[a]) return 0;
            return 1;
        endfunction

        function int elev_at(int unsigned r, int unsigned c);
            return int'(elev_mem[r * cols() + c]);
        endfunction

        function int unsigned height_change(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        // One greedy move into the next column; ties keep straight, down beats up
        function int unsigned take_step(int unsigned row, int unsigned col,
                                        output int unsigned delta);
            int          here;
            int unsigned d_s, d_u, d_d;
            here = elev_at(row, col);
            d_s  = height_change(elev_at(row, col + 1), here);
            if (row == 0) begin
                d_d = height_change(elev_at(row + 1, col + 1), here);
                if (d_d < d_s) begin
                    delta = d_d;
                    return row + 1;
                end
                delta = d_s;
                return row;
            end
            if (row == rows() - 1) begin
                d_u = height_change(elev_at(row - 1, col + 1), here);
                if (d_u < d_s) begin
                    delta = d_u;
                    return row - 1;
                end
                delta = d_s;
                return row;
            end
            d_d = height_change(elev_at(row + 1, col + 1), here);
            d_u = height_change(elev_at(row - 1, col + 1), here);
            if (d_d <= d_u && d_d < d_s) begin
                delta = d_d;
                return row + 1;
            end
            if (d_u < d_s && d_u < d_d) begin
                delta = d_u;
                return row - 1;
            end
            delta = d_s;
            return row;
        endfunction

        // Walk from one start row; totals saturate at the top of 24 bits
        function int unsigned walk_from(int unsigned start, bit trace);
            int unsigned row, total, delta;
            row   = start;
            total = 0;
            if (trace) trace_mem[0] = row[7:0];
            for (int c = 0; c + 1 < cols(); c++) begin
                row = take_step(row, c, delta);
                total = (delta > gmep_pkg::TOTAL_MAX - total) ? gmep_pkg::TOTAL_MAX
                                                              : total + delta;
                if (trace) trace_mem[c + 1] = row[7:0];
            end
            return total;
        endfunction

        // Accepted input word: update the mirror, queue any expected result
        function void note_word(logic [1:0] c, logic [gmep_pkg::IN_ELEV_W-1:0] e,
                                logic [gmep_pkg::COL_W-1:0] col);
            int unsigned  best, low, t;
            path_answer_t ans;
            case (gmep_pkg::cmd_t'(c))
                gmep_pkg::CMD_LOAD: begin
                    elev_mem[load_ptr]      = e;
                    sample_loaded[load_ptr] = 1;
                    load_ptr++;
                    if (load_ptr >= cols() * rows()) load_ptr = 0;
                end
                gmep_pkg::CMD_RUN: begin
                    best = 0;
                    low  = walk_from(0, 0);
                    for (int r = 1; r < rows(); r++) begin
                        t = walk_from(r, 0);
                        if (t < low) begin
                            low  = t;
                            best = r;
                        end
                    end
                    void'(walk_from(best, 1));
                    best_start   = best[7:0];
                    lowest_total = low[23:0];
                    ans = '{gmep_pkg::KIND_RUN, best_start, lowest_total, 8'd0};
                    answers.insert(answers.size(), ans);
                end
                gmep_pkg::CMD_READ: begin
                    ans = '{gmep_pkg::KIND_PATH, best_start, lowest_total,
                            (col < cols()) ? trace_mem[col] : 8'd0};
                    answers.insert(answers.size(), ans);
                end
                default: ;
            endcase
        endfunction

        function void compare(string name, logic [gmep_pkg::TOTAL_W-1:0] want,
                              logic [gmep_pkg::TOTAL_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic kind, logic [gmep_pkg::ROW_OUT_W-1:0] brow,
                                   logic [gmep_pkg::TOTAL_W-1:0] tot,
                                   logic [gmep_pkg::ROW_OUT_W-1:0] prow);
            path_answer_t ans;
            if (answers.size() == 0) begin
                $display("%0t: extra result: expected none, got %0d/%0d/%0d/%0d",
                         $time, kind, brow, tot, prow);
                errors++;
                return;
            end
            ans = answers.pop_front();
            compare("result_kind", gmep_pkg::TOTAL_W'(ans.kind), gmep_pkg::TOTAL_W'(kind));
            compare("best_row", gmep_pkg::TOTAL_W'(ans.start_row), gmep_pkg::TOTAL_W'(brow));
            compare("best_total", ans.total, tot);
            compare("path_row", gmep_pkg::TOTAL_W'(ans.row_at_col), gmep_pkg::TOTAL_W'(prow));
        endfunction
    endclass

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_stall;
    logic [1:0]                      cmd         = gmep_pkg::CMD_NONE;
    logic [gmep_pkg::IN_ELEV_W-1:0]  elevation   = '0;
    logic [gmep_pkg::COL_W-1:0]      column      = '0;
    logic                            out_valid;
    logic                            out_stall   = 1'b0;
    logic                            result_kind;
    logic [gmep_pkg::ROW_OUT_W-1:0]  best_row;
    logic [gmep_pkg::TOTAL_W-1:0]    best_total;
    logic [gmep_pkg::ROW_OUT_W-1:0]  path_row;
    logic                            cfg_we      = 1'b0;
    logic [gmep_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [gmep_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

    path_scoreboard sb = new();
    int             cycles = 0;
    int             word_count = 0;
    bit             quiet = 0;

    greedy_min_elevation_path_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .elevation   (elevation),
        .column      (column),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .best_row    (best_row),
        .best_total  (best_total),
        .path_row    (path_row),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_kind, best_row, best_total, path_row);
    end

    // Receiver stalls in random bursts, none once the run winds down
    initial
    begin
        int n;
        @(posedge rst_n);
        forever begin
            n = $urandom_range(1, 14);
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge clk);
            end
        end
    end

    function automatic logic [gmep_pkg::IN_ELEV_W-1:0] rand_elev();
        int v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom_range(0, 65535);
            2, 3: v = $urandom_range(0, 8) - 4;   // narrow spread, lots of ties
            4: begin
                case ($urandom_range(0, 3))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 0;
                    default: v = 16'hFFFF;
                endcase
            end
            default: v = $urandom_range(0, 2000) - 1000;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [gmep_pkg::CFG_DATA_W-1:0] rand_width();
        case ($urandom_range(0, 9))
            0: return gmep_pkg::CFG_DATA_W'($urandom_range(0, 1));
            1: return gmep_pkg::CFG_DATA_W'($urandom_range(9, 20));
            default: return gmep_pkg::CFG_DATA_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [gmep_pkg::CFG_DATA_W-1:0] rand_height();
        if ($urandom_range(0, 9) == 0) return gmep_pkg::CFG_DATA_W'($urandom_range(0, 1));
        return gmep_pkg::CFG_DATA_W'($urandom_range(2, 8));
    endfunction

    // Mostly inside the traced width, sometimes past it
    function automatic logic [gmep_pkg::COL_W-1:0] pick_column();
        int w;
        w = sb.cols();
        if (w < 256 && $urandom_range(0, 4) == 0) return 8'($urandom_range(w, 255));
        return 8'($urandom_range(0, w - 1));
    endfunction

    // Send one input word, with an optional idle burst ahead of it
    task automatic send_word(logic [1:0] c, logic [gmep_pkg::IN_ELEV_W-1:0] e,
                             logic [gmep_pkg::COL_W-1:0] col);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        elevation <= e;
        column    <= col;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(c, e, col);
        word_count++;
    endtask

    task automatic write_reg(logic [gmep_pkg::CFG_IDX_W-1:0] idx,
                             logic [gmep_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected result is out and trailing loads are done
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic fill_grid();
        while (!sb.grid_ready())
            send_word(gmep_pkg::CMD_LOAD, rand_elev(), 8'($urandom));
    endtask

    // Resize, load a full grid, run, then mix loads, runs, reads and junk
    task automatic grid_phase(logic [gmep_pkg::CFG_DATA_W-1:0] w_raw,
                              logic [gmep_pkg::CFG_DATA_W-1:0] h_raw, int n_ops);
        int pick;
        drain();
        write_reg(gmep_pkg::CFG_WIDTH, w_raw);
        write_reg(gmep_pkg::CFG_HEIGHT, h_raw);
        fill_grid();
        send_word(gmep_pkg::CMD_RUN, rand_elev(), 8'($urandom));
        repeat (n_ops) begin
            pick = $urandom_range(0, 19);
            if (pick < 5)
                send_word(gmep_pkg::CMD_LOAD, rand_elev(), 8'($urandom));
            else if (pick < 9)
                send_word(gmep_pkg::CMD_RUN, rand_elev(), 8'($urandom));
            else if (pick < 19)
                send_word(gmep_pkg::CMD_READ, rand_elev(), pick_column());
            else
                send_word(gmep_pkg::CMD_NONE, rand_elev(), 8'($urandom));
        end
    endtask

    // 3x3 grid with a straight/down tie on the top row, a down/up tie in
    // the middle and full-scale samples; then a single-column run
    task automatic directed_part();
        logic [gmep_pkg::IN_ELEV_W-1:0] grid [9];
        grid = '{16'd10, 16'd0,  16'h7FFF,
                 16'd5,  16'd20, 16'h8000,
                 16'h8000, 16'd10, 16'd0};
        write_reg(gmep_pkg::CFG_WIDTH, 9'd3);
        write_reg(gmep_pkg::CFG_HEIGHT, 9'd3);
        foreach (grid[i]) send_word(gmep_pkg::CMD_LOAD, grid[i], 8'hFF);
        send_word(gmep_pkg::CMD_NONE, 16'h8000, 8'h00);
        send_word(gmep_pkg::CMD_RUN, 16'h0000, 8'h00);
        for (int c = 0; c < 4; c++) send_word(gmep_pkg::CMD_READ, 16'h0000, c[7:0]);
        send_word(gmep_pkg::CMD_READ, 16'hFFFF, 8'hFF);
        // width below range clamps to a single column
        drain();
        write_reg(gmep_pkg::CFG_WIDTH, 9'd0);
        send_word(gmep_pkg::CMD_RUN, 16'h0000, 8'h00);
        send_word(gmep_pkg::CMD_READ, 16'h0000, 8'd0);
        send_word(gmep_pkg::CMD_READ, 16'h0000, 8'd1);
    endtask

    task automatic random_part();
        int phase_no;
        phase_no   = 0;
        word_count = 0;
        while (word_count < RANDOM_WORDS) begin
            quiet = (word_count > RANDOM_WORDS - 60);
            case (phase_no)
                1: grid_phase(9'd0, 9'd300, 12);   // tallest, both clamped
                default: grid_phase(rand_width(), rand_height(), $urandom_range(4, 16));
            endcase
            phase_no++;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        random_part();
        drain();
        if (sb.errors == 0 && sb.answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
